// ===== design/cftc_pkg.sv =====
package cftc_pkg;

  localparam int unsigned MAX_TOKENS = 10;
  localparam int unsigned TOK_W = 4;

  localparam logic [7:0] START_BYTE_RESET = 8'h24;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [TOK_W-1:0] MAX_TOK = TOK_W'(MAX_TOKENS);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_TOKENS = 2'd1,
    PH_CHECK  = 2'd2,
    PH_IGNORE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_SEP   = 2'd1,
    KIND_CHECK = 2'd2
  } byte_kind_t;

  typedef enum logic [1:0] {
    CK_NONE = 2'd0,
    CK_ADD  = 2'd1,
    CK_XOR  = 2'd2,
    CK_OVER = 2'd3
  } check_kind_t;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ===== design/cftc_ifs.sv =====
interface cftc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface cftc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_number;
  logic [1:0] byte_kind;
  logic       frame_done;
  logic       frame_ok;
  logic [3:0] token_count;
  logic [1:0] check_kind;

  modport source (output valid, output token_number, output byte_kind, output frame_done,
                  output frame_ok, output token_count, output check_kind, input ready);
  modport sink   (input valid, input token_number, input byte_kind, input frame_done,
                  input frame_ok, input token_count, input check_kind, output ready);
endinterface

interface cftc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/command_frame_tokenize_check_top.sv =====
// A result word is written into the output register when its byte is accepted.
// Throughput: 1 byte per cycle unless stalled; parse state and output update together.
// in_ch.ready stays high while the output register is empty or being taken.
// Reset (rst_n low, synchronous): parse state cleared, output empty, start byte 0x24.
// cfg_ch.ready is always high.
module command_frame_tokenize_check_top (
  input logic       clk,
  input logic       rst_n,
  cftc_in_if.sink   in_ch,
  cftc_out_if.source out_ch,
  cftc_cfg_if.sink  cfg_ch
);
  import cftc_pkg::*;

  logic [7:0]       start_r;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       add_r, add_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [TOK_W-1:0] toks_r, toks_nxt;
  check_kind_t      chk_r, chk_nxt;
  logic [7:0]       rcv_r, rcv_nxt;
  logic [1:0]       hexn_r, hexn_nxt;
  logic             hexbad_r, hexbad_nxt;

  logic             out_valid_r;
  logic [TOK_W-1:0] tok_num_r, tok_num_nxt;
  byte_kind_t       kind_r, kind_nxt;
  logic             done_r, ok_r, ok_nxt;
  logic [TOK_W-1:0] tcount_r, tcount_nxt;
  check_kind_t      ckind_r, ckind_nxt;

  logic             in_acc;
  logic [7:0]       b;
  logic [TOK_W-1:0] cur;
  logic [4:0]       hx;
  logic             hex_good;

  assign b      = in_ch.data_byte;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cur    = (toks_r != '0) ? toks_r - 1'b1 : '0;
  assign hx     = hex_digit(b);

  // next parse phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_FIRST: phase_nxt = PH_TOKENS;
      PH_TOKENS: begin
        if (b == CH_NUL) begin
          phase_nxt = PH_IGNORE;
        end else if (b == CH_SPACE) begin
          if (toks_r >= MAX_TOK) phase_nxt = PH_IGNORE;
        end else if (b == CH_STAR || b == CH_CARET) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK:  phase_nxt = PH_CHECK;
      PH_IGNORE: phase_nxt = PH_IGNORE;
      default:   phase_nxt = PH_FIRST;
    endcase
    if (in_ch.frame_last) phase_nxt = PH_FIRST;
  end

  // datapath and result word
  always_comb begin
    add_nxt     = add_r;
    xor_nxt     = xor_r;
    toks_nxt    = toks_r;
    chk_nxt     = chk_r;
    rcv_nxt     = rcv_r;
    hexn_nxt    = hexn_r;
    hexbad_nxt  = hexbad_r;
    tok_num_nxt = cur;
    kind_nxt    = KIND_CHECK;
    case (phase_r)
      PH_FIRST: begin
        add_nxt     = start_r + b;
        xor_nxt     = start_r ^ b;
        toks_nxt    = TOK_W'(1);
        chk_nxt     = CK_NONE;
        rcv_nxt     = '0;
        hexn_nxt    = '0;
        hexbad_nxt  = 1'b0;
        tok_num_nxt = '0;
        kind_nxt    = KIND_TOKEN;
      end
      PH_TOKENS: begin
        if (b == CH_NUL) begin
          kind_nxt = KIND_CHECK;
        end else if (b == CH_SPACE) begin
          kind_nxt    = KIND_SEP;
          tok_num_nxt = toks_r;
          if (toks_r >= MAX_TOK) begin
            chk_nxt = CK_OVER;
          end else begin
            add_nxt  = add_r + b;
            xor_nxt  = xor_r ^ b;
            toks_nxt = toks_r + 1'b1;
          end
        end else if (b == CH_STAR || b == CH_CARET) begin
          chk_nxt  = (b == CH_STAR) ? CK_ADD : CK_XOR;
          kind_nxt = KIND_CHECK;
        end else begin
          add_nxt  = add_r + b;
          xor_nxt  = xor_r ^ b;
          kind_nxt = KIND_TOKEN;
        end
      end
      PH_CHECK: begin
        if (hexn_r < 2'd2) begin
          if (!hx[4]) begin
            hexbad_nxt = 1'b1;
            hexn_nxt   = 2'd2;
          end else begin
            rcv_nxt  = {rcv_r[3:0], hx[3:0]};
            hexn_nxt = hexn_r + 1'b1;
          end
        end
      end
      default: ;
    endcase

    hex_good = !hexbad_nxt && (hexn_nxt == 2'd2);
    case (chk_nxt)
      CK_NONE: ok_nxt = 1'b1;
      CK_ADD:  ok_nxt = hex_good && (rcv_nxt == add_nxt);
      CK_XOR:  ok_nxt = hex_good && (rcv_nxt == xor_nxt);
      default: ok_nxt = 1'b0;
    endcase
    if (!in_ch.frame_last) ok_nxt = 1'b0;
    tcount_nxt = ok_nxt ? toks_nxt : '0;
    ckind_nxt  = in_ch.frame_last ? chk_nxt : CK_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_BYTE_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      start_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      add_r    <= '0;
      xor_r    <= '0;
      toks_r   <= '0;
      chk_r    <= CK_NONE;
      rcv_r    <= '0;
      hexn_r   <= '0;
      hexbad_r <= 1'b0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      add_r    <= add_nxt;
      xor_r    <= xor_nxt;
      toks_r   <= toks_nxt;
      chk_r    <= chk_nxt;
      rcv_r    <= rcv_nxt;
      hexn_r   <= hexn_nxt;
      hexbad_r <= hexbad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tok_num_r <= tok_num_nxt;
      kind_r    <= kind_nxt;
      done_r    <= in_ch.frame_last;
      ok_r      <= ok_nxt;
      tcount_r  <= tcount_nxt;
      ckind_r   <= ckind_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.token_number = tok_num_r;
  assign out_ch.byte_kind    = kind_r;
  assign out_ch.frame_done   = done_r;
  assign out_ch.frame_ok     = ok_r;
  assign out_ch.token_count  = tcount_r;
  assign out_ch.check_kind   = ckind_r;

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !done_r) |-> (!ok_r && tcount_r == '0 && ckind_r == CK_NONE))
    else $error("non-final word carries frame status");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.frame_last) |=> (phase_r == PH_FIRST))
    else $error("parser not back at first byte after frame end");

  a_over_fails: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ckind_r == CK_OVER) |-> !ok_r)
    else $error("overflowed frame reported ok");

  a_tok_bound: assert property (@(posedge clk) disable iff (!rst_n)
    toks_r <= MAX_TOK)
    else $error("token count beyond limit");

  a_first_tok: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_FIRST) |-> (toks_r != '0))
    else $error("open frame without a token");

endmodule

// ===== verif/command_frame_tokenize_check_top_tb.sv =====
module command_frame_tokenize_check_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cftc_pkg::*;

  localparam logic [7:0] ASC_ZERO = 8'h30;
  localparam logic [7:0] ASC_UP_A = 8'h41;
  localparam logic [7:0] ASC_LO_A = 8'h61;
  localparam logic [15:0] RX_RANDOM = 16'h0000;

  typedef struct packed {
    logic [3:0]  token_number;
    byte_kind_t  byte_kind;
    logic        frame_done;
    logic        frame_ok;
    logic [3:0]  token_count;
    check_kind_t check_kind;
  } result_word_t;

  logic clk;
  logic rst_n;

  cftc_in_if  in_ch();
  cftc_out_if out_ch();
  cftc_cfg_if cfg_ch();

  command_frame_tokenize_check_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // frame checker state
  logic [7:0]  start_val;
  phase_t      ph;
  logic [7:0]  add_sum;
  logic [7:0]  xor_sum;
  logic [3:0]  tok_seen;
  check_kind_t chk;
  logic [7:0]  rx_sum;
  logic [1:0]  hex_cnt;
  logic        hex_bad;

  result_word_t expected_words[$];
  int          fail_count = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;
  int          gap_max = 0;
  logic [15:0] rx_pattern = 16'hFFFF;
  logic [3:0]  rx_phase = 4'd0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int nib_of(input logic [7:0] c);
    if (c >= ASC_ZERO && c <= ASC_ZERO + 8'd9) return int'(c - ASC_ZERO);
    if (c >= ASC_UP_A && c <= ASC_UP_A + 8'd5) return int'(c - ASC_UP_A) + 10;
    if (c >= ASC_LO_A && c <= ASC_LO_A + 8'd5) return int'(c - ASC_LO_A) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    if (n < 4'd10) return ASC_ZERO + 8'(n);
    return (upper ? ASC_UP_A : ASC_LO_A) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (nib_of(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_SPACE || c == CH_STAR || c == CH_CARET || c == CH_NUL);
    return c;
  endfunction

  function automatic logic [7:0] special_byte();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_STAR;
      2: return CH_CARET;
      default: return CH_NUL;
    endcase
  endfunction

  function automatic logic [7:0] frame_sum(input logic [7:0] fr[$], input logic use_xor);
    logic [7:0] s;
    s = start_val;
    foreach (fr[i]) s = use_xor ? (s ^ fr[i]) : (s + fr[i]);
    return s;
  endfunction

  function automatic string word_str(input result_word_t w);
    return $sformatf("tok=%0d kind=%0d done=%0b ok=%0b count=%0d check=%0d",
                     w.token_number, w.byte_kind, w.frame_done, w.frame_ok,
                     w.token_count, w.check_kind);
  endfunction

  function automatic void reset_checker_state();
    start_val = START_BYTE_RESET;
    ph        = PH_FIRST;
    add_sum   = 8'd0;
    xor_sum   = 8'd0;
    tok_seen  = 4'd0;
    chk       = CK_NONE;
    rx_sum    = 8'd0;
    hex_cnt   = 2'd0;
    hex_bad   = 1'b0;
  endfunction

  function automatic result_word_t predict_byte(input logic [7:0] b, input logic last);
    result_word_t r;
    logic [3:0] cur;
    int v;
    logic good;
    logic ok;
    r = '0;
    cur = (tok_seen != 4'd0) ? tok_seen - 4'd1 : 4'd0;
    r.token_number = cur;
    r.byte_kind = KIND_CHECK;
    case (ph)
      PH_FIRST: begin
        add_sum  = start_val + b;
        xor_sum  = start_val ^ b;
        tok_seen = 4'd1;
        chk      = CK_NONE;
        rx_sum   = 8'd0;
        hex_cnt  = 2'd0;
        hex_bad  = 1'b0;
        r.token_number = 4'd0;
        r.byte_kind = KIND_TOKEN;
        ph = PH_TOKENS;
      end
      PH_TOKENS: begin
        if (b == CH_NUL) begin
          ph = PH_IGNORE;
        end else if (b == CH_SPACE) begin
          r.byte_kind = KIND_SEP;
          r.token_number = tok_seen;
          if (tok_seen >= MAX_TOK) begin
            chk = CK_OVER;
            ph = PH_IGNORE;
          end else begin
            add_sum = add_sum + b;
            xor_sum = xor_sum ^ b;
            tok_seen = tok_seen + 4'd1;
          end
        end else if (b == CH_STAR || b == CH_CARET) begin
          chk = (b == CH_STAR) ? CK_ADD : CK_XOR;
          ph = PH_CHECK;
        end else begin
          add_sum = add_sum + b;
          xor_sum = xor_sum ^ b;
          r.byte_kind = KIND_TOKEN;
        end
      end
      PH_CHECK: begin
        if (hex_cnt < 2'd2) begin
          v = nib_of(b);
          if (v < 0) begin
            hex_bad = 1'b1;
            hex_cnt = 2'd2;
          end else begin
            rx_sum = {rx_sum[3:0], 4'(v)};
            hex_cnt = hex_cnt + 2'd1;
          end
        end
      end
      default: ;
    endcase
    if (last) begin
      good = !hex_bad && hex_cnt == 2'd2;
      case (chk)
        CK_NONE: ok = 1'b1;
        CK_ADD:  ok = good && rx_sum == add_sum;
        CK_XOR:  ok = good && rx_sum == xor_sum;
        default: ok = 1'b0;
      endcase
      r.frame_done  = 1'b1;
      r.frame_ok    = ok;
      r.token_count = ok ? tok_seen : 4'd0;
      r.check_kind  = chk;
      ph = PH_FIRST;
    end
    return r;
  endfunction

  // result side: backpressure pattern and compare
  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.token_number = out_ch.token_number;
        got.byte_kind    = byte_kind_t'(out_ch.byte_kind);
        got.frame_done   = out_ch.frame_done;
        got.frame_ok     = out_ch.frame_ok;
        got.token_count  = out_ch.token_count;
        got.check_kind   = check_kind_t'(out_ch.check_kind);
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: unexpected result %s", $time, word_str(got));
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch, expected %s, got %s", $time, word_str(want),
                       word_str(got));
            end
          end
        end
      end
      rx_phase <= rx_phase + 4'd1;
      out_ch.ready <= (rx_pattern == RX_RANDOM) ? 1'($urandom_range(0, 1))
                                                : rx_pattern[rx_phase];
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.frame_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    expected_words.push_back(predict_byte(b, last));
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] fr[$]);
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_words.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_start_byte(input logic [7:0] v);
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    start_val = v;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly well-formed frames with random content, some noise and broken checks
  task automatic send_random_frame();
    logic [7:0] fr[$];
    logic [7:0] c;
    int n_sep, n_body, pick, fault, bad_at;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      n_body = $urandom_range(1, 10);
      repeat (n_body) begin
        fr.push_back(($urandom_range(0, 3) == 0) ? special_byte() : 8'($urandom_range(0, 255)));
      end
      send_frame(fr);
    end else begin
      fr.push_back(8'($urandom_range(0, 255)));
      n_sep = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 3);
      for (int k = 0; k <= n_sep; k++) begin
        if (k > 0) fr.push_back(CH_SPACE);
        n_body = $urandom_range(0, 3);
        repeat (n_body) fr.push_back(plain_byte());
      end
      if ($urandom_range(0, 24) == 0) fr.insert($urandom_range(1, fr.size()), CH_NUL);
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        send_frame(fr);
      end else begin
        c = frame_sum(fr, pick >= 6);
        fault = $urandom_range(0, 9);
        if (fault == 0) c = c ^ 8'(1 << $urandom_range(0, 7));
        fr.push_back((pick < 6) ? CH_STAR : CH_CARET);
        if (fault == 2) begin
          if ($urandom_range(0, 1)) fr.push_back(hex_char(c[7:4], 1'($urandom_range(0, 1))));
        end else begin
          bad_at = (fault == 1) ? $urandom_range(0, 1) : 2;
          fr.push_back((bad_at == 0) ? non_hex() : hex_char(c[7:4], 1'($urandom_range(0, 1))));
          fr.push_back((bad_at == 1) ? non_hex() : hex_char(c[3:0], 1'($urandom_range(0, 1))));
          n_body = $urandom_range(0, 2);
          repeat (n_body) fr.push_back(8'($urandom_range(0, 255)));
        end
        send_frame(fr);
      end
    end
  endtask

  task automatic test_directed();
    logic [7:0] fr[$];
    logic [7:0] c;
    gap_max = 0;
    rx_pattern = 16'hFFFF;
    // zero as first byte, one-byte frame
    fr = '{CH_NUL};
    send_frame(fr);
    // all-ones byte, xor check, upper case digits
    fr = '{8'hFF};
    c = frame_sum(fr, 1'b1);
    fr.push_back(CH_CARET);
    fr.push_back(hex_char(c[7:4], 1'b1));
    fr.push_back(hex_char(c[3:0], 1'b1));
    send_frame(fr);
    // marker as first byte, additive check, lower case digits, trailing byte
    fr = '{CH_STAR};
    c = frame_sum(fr, 1'b0);
    fr.push_back(CH_STAR);
    fr.push_back(hex_char(c[7:4], 1'b0));
    fr.push_back(hex_char(c[3:0], 1'b0));
    fr.push_back(8'h7E);
    send_frame(fr);
    // NUL inside tokens stops parsing
    fr = '{8'h61, CH_NUL, CH_STAR};
    send_frame(fr);
    // space as first byte, then one separator too many
    fr = '{CH_SPACE};
    repeat (MAX_TOKENS) fr.push_back(CH_SPACE);
    send_frame(fr);
    // non-hex check digit
    fr = '{8'h71, CH_STAR, 8'h47, 8'h31};
    send_frame(fr);
    // only one check digit
    fr = '{8'h71, CH_CARET, 8'h31};
    send_frame(fr);
    drain();
  endtask

  task automatic test_start_byte();
    logic [7:0] seeds[$];
    seeds = '{8'h00, 8'hFF, 8'($urandom_range(1, 254))};
    gap_max = 2;
    rx_pattern = 16'hB6E5;
    foreach (seeds[i]) begin
      write_start_byte(seeds[i]);
      repeat (5) send_random_frame();
      drain();
    end
  endtask

  task automatic run_phase(input logic [7:0] seed, input int gap, input logic [15:0] pat,
                           input int n_bytes);
    int stop_at;
    write_start_byte(seed);
    gap_max = gap;
    rx_pattern = pat;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_frame();
    drain();
  endtask

  task automatic test_random_frames();
    run_phase(START_BYTE_RESET, 0, 16'hFFFF, 90);
    run_phase(8'($urandom_range(0, 255)), 3, 16'hB6E5, 90);
    run_phase(8'($urandom_range(0, 255)), 0, 16'h00FF, 90);
    run_phase(8'($urandom_range(0, 255)), 8, RX_RANDOM, 90);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.frame_last = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 8'd0;
    reset_checker_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_start_byte();
    test_random_frames();

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("** command_frame_tokenize_check_top: PASSED **");
    end else begin
      $display("** command_frame_tokenize_check_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("** command_frame_tokenize_check_top: FAILED **");
    $finish;
  end

endmodule
